// File: design/ngd_pkg.sv
// ----------------------------------------------------------------------------
// ngd_pkg
// Shared types and constants of the neighbour Gaussian density block.
// ----------------------------------------------------------------------------
package ngd_pkg;

   localparam int NB_MAX    = 32;
   localparam int IDX_W     = $clog2(NB_MAX);
   localparam int CNT_W     = $clog2(NB_MAX + 2);
   localparam int ADDR_W    = IDX_W + 1;
   localparam int RAM_DEPTH = 2 * NB_MAX;
   localparam int JOB_SLOTS = 2;
   localparam int SLOT_W    = $clog2(JOB_SLOTS + 1);

   localparam logic [0:0]  CSR_SIGMA    = 1'd0;
   localparam logic [0:0]  CSR_WEIGHTED = 1'd1;
   localparam logic [15:0] SIGMA_RESET  = 16'd1280;

   localparam logic [32:0] INV_SQRT_2PI = 33'd1713444047;
   localparam logic [32:0] RECIP_3      = 33'h0AAAAAAAB;
   localparam logic [31:0] EXP_LIMIT    = 32'd23 << 16;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_ZERO_SPREAD = 2'd1,
      ST_OVERFLOW    = 2'd2
   } status_type;

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic [31:0]      max;
      status_type       status;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [63:0]       data;
   } ram_wr_type;

   typedef enum logic [4:0] {
      BK_IDLE, BK_SQRT, BK_MULF, BK_DIVF, BK_MULS, BK_RD, BK_RDW, BK_DIVQ,
      BK_MULX, BK_EXPC, BK_T2, BK_T3, BK_T4, BK_D6, BK_D24, BK_POLY, BK_SQ,
      BK_G1, BK_G2, BK_W1, BK_W2, BK_ACC, BK_OUT
   } back_state_type;

endpackage

// File: design/neighbour_gaussian_density.sv
// ----------------------------------------------------------------------------
// neighbour_gaussian_density
// Adaptive Gaussian kernel density over a set of stored neighbours.
// ----------------------------------------------------------------------------
// Input: one neighbour per cycle while one of two store banks is free.
// Result: after the last item, a setup (32-step square root, 64-step
// divide), then per neighbour a pass through the shared 64-step divider and
// the single shared multiplier, with extra multiplier steps in weighted mode
// and fewer when the exponential clamps; error sets skip all of this.
// Reset clears control state and the configuration; the stores keep data.
module neighbour_gaussian_density (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // dist_sq[31:0], mass[63:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // density[31:0]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0]         sigma_ff;
   logic                weighted_ff;
   ngd_pkg::ram_wr_type ram_wr;
   ngd_pkg::job_type    push_job, pop_job;
   logic                job_push, job_pop, job_valid, job_done;
   logic                rd_en;
   logic [ngd_pkg::ADDR_W-1:0] rd_addr;
   logic [63:0]         rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff    <= ngd_pkg::SIGMA_RESET;
         weighted_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            ngd_pkg::CSR_SIGMA:    sigma_ff    <= csr_wdata;
            ngd_pkg::CSR_WEIGHTED: weighted_ff <= csr_wdata[0];
            default:               sigma_ff    <= sigma_ff;
         endcase
      end
   end

   ngd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .job_done   (job_done),
      .ram_wr     (ram_wr),
      .job_push   (job_push),
      .job        (push_job)
   );

   ngd_ram #(
      .WIDTH (64),
      .DEPTH (ngd_pkg::RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ngd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .pop_valid (job_valid),
      .pop_job   (pop_job)
   );

   ngd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .sigma_count   (sigma_ff),
      .weighted_mode (weighted_ff),
      .job_valid     (job_valid),
      .job           (pop_job),
      .job_pop       (job_pop),
      .job_done      (job_done),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

// File: design/ngd_ram.sv
// ----------------------------------------------------------------------------
// ngd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ngd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ngd_front.sv
// ----------------------------------------------------------------------------
// ngd_front
// Accepts neighbours, stores them in the current bank, tracks count and
// maximum distance, and issues one job per set.
// ----------------------------------------------------------------------------
module ngd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [63:0]         req_tdata,
   input  logic                req_tlast,
   input  logic                job_done,
   output ngd_pkg::ram_wr_type ram_wr,
   output logic                job_push,
   output ngd_pkg::job_type    job
);

   logic [ngd_pkg::CNT_W-1:0]  count_ff, count_in, count_inc;
   logic [31:0]                max_ff, max_in, max_next;
   logic                       bank_ff, bank_in;
   logic [ngd_pkg::SLOT_W-1:0] outst_ff, outst_in;
   logic                       accept;
   logic [31:0]                dist_sq;

   assign dist_sq    = req_tdata[31:0];
   assign req_tready = outst_ff < ngd_pkg::SLOT_W'(ngd_pkg::JOB_SLOTS);
   assign accept     = req_tvalid && req_tready;
   assign count_inc  = (count_ff <= ngd_pkg::CNT_W'(ngd_pkg::NB_MAX)) ?
                       count_ff + 1'b1 : count_ff;
   assign max_next   = (dist_sq > max_ff) ? dist_sq : max_ff;

   always_comb begin
      count_in = count_ff;
      max_in   = max_ff;
      bank_in  = bank_ff;
      job_push = 1'b0;
      if (accept) begin
         if (req_tlast) begin
            count_in = '0;
            max_in   = '0;
            bank_in  = ~bank_ff;
            job_push = 1'b1;
         end else begin
            count_in = count_inc;
            max_in   = max_next;
         end
      end
      outst_in = outst_ff + ngd_pkg::SLOT_W'(job_push) - ngd_pkg::SLOT_W'(job_done);
   end

   always_comb begin
      job.bank  = bank_ff;
      job.count = count_inc;
      job.max   = max_next;
      if (count_inc > ngd_pkg::CNT_W'(ngd_pkg::NB_MAX)) begin
         job.status = ngd_pkg::ST_OVERFLOW;
      end else if (max_next == '0) begin
         job.status = ngd_pkg::ST_ZERO_SPREAD;
      end else begin
         job.status = ngd_pkg::ST_OK;
      end
   end

   assign ram_wr.en   = accept && (count_ff < ngd_pkg::CNT_W'(ngd_pkg::NB_MAX));
   assign ram_wr.addr = {bank_ff, count_ff[ngd_pkg::IDX_W-1:0]};
   assign ram_wr.data = req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= '0;
         bank_ff  <= 1'b0;
         outst_ff <= '0;
      end else begin
         count_ff <= count_in;
         max_ff   <= max_in;
         bank_ff  <= bank_in;
         outst_ff <= outst_in;
      end
   end

   a_outst_bound: assert property (@(posedge clock) disable iff (reset)
      outst_ff <= ngd_pkg::SLOT_W'(ngd_pkg::JOB_SLOTS))
      else $error("outstanding jobs exceed bank count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ngd_pkg::CNT_W'(ngd_pkg::NB_MAX + 1))
      else $error("item count beyond saturation");

   a_set_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> count_ff == '0 && max_ff == '0 && bank_ff != $past(bank_ff))
      else $error("set end did not restart front");

endmodule

// File: design/ngd_queue.sv
// ----------------------------------------------------------------------------
// ngd_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module ngd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ngd_pkg::job_type push_job,
   input  logic             pop,
   output logic             pop_valid,
   output ngd_pkg::job_type pop_job
);

   ngd_pkg::job_type           slot_ff [ngd_pkg::JOB_SLOTS];
   logic                       wr_ptr_ff, rd_ptr_ff;
   logic [ngd_pkg::SLOT_W-1:0] fill_ff;

   assign pop_valid = fill_ff != '0;
   assign pop_job   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop && pop_valid) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_ff + ngd_pkg::SLOT_W'(push)
                    - ngd_pkg::SLOT_W'(pop && pop_valid);
      end
   end

endmodule

// File: design/ngd_back.sv
// ----------------------------------------------------------------------------
// ngd_back
// Computes the density of one set: square root and factor division once,
// then per neighbour a ratio division, exponential and scaling on one
// shared multiplier, with a saturating sum and an output register.
// ----------------------------------------------------------------------------
module ngd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [15:0]                 sigma_count,
   input  logic                        weighted_mode,
   input  logic                        job_valid,
   input  ngd_pkg::job_type            job,
   output logic                        job_pop,
   output logic                        job_done,
   output logic                        rd_en,
   output logic [ngd_pkg::ADDR_W-1:0]  rd_addr,
   input  logic [63:0]                 rd_data,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,
   output logic [1:0]                  rsp_tuser
);

   ngd_pkg::back_state_type   state_ff, state_in;
   ngd_pkg::job_type          job_ff, job_in;
   logic [ngd_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [5:0]                step_ff, step_in;
   logic [63:0]               sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [63:0]               f_ff, f_in, dvd_ff, dvd_in, quo_ff, quo_in;
   logic [31:0]               div_ff, div_in, rem_ff, rem_in;
   logic [31:0]               s2_ff, s2_in, mass_ff, mass_in, x_ff, x_in;
   logic [31:0]               t_ff, t_in, t2_ff, t2_in, t3_ff, t3_in, t4_ff, t4_in;
   logic [31:0]               c6_ff, c6_in, c24_ff, c24_in, acc_ff, acc_in;
   logic [32:0]               p_ff, p_in;
   logic [64:0]               lo_ff, lo_in;
   logic [63:0]               g_ff, g_in, term_ff, term_in;
   logic                      out_valid_ff, out_valid_in;
   logic [31:0]               out_dens_ff, out_dens_in;
   logic [1:0]                out_stat_ff, out_stat_in;

   logic [32:0] mul_a, mul_b;
   logic [65:0] prod;
   logic [63:0] sq_trial;
   logic [32:0] rem_sh;
   logic        div_ge;
   logic [33:0] poly;
   logic [65:0] sq_round;
   logic [32:0] acc_sum;
   logic [ngd_pkg::CNT_W-1:0] idx_next;

   always_comb begin
      unique case (state_ff)
         ngd_pkg::BK_MULF: begin mul_a = 33'(sigma_count); mul_b = ngd_pkg::INV_SQRT_2PI; end
         ngd_pkg::BK_MULS: begin mul_a = 33'(sigma_count); mul_b = 33'(sigma_count); end
         ngd_pkg::BK_MULX: begin mul_a = quo_ff[32:0]; mul_b = 33'(s2_ff); end
         ngd_pkg::BK_T2:   begin mul_a = 33'(t_ff); mul_b = 33'(t_ff); end
         ngd_pkg::BK_T3:   begin mul_a = 33'(t2_ff); mul_b = 33'(t_ff); end
         ngd_pkg::BK_T4:   begin mul_a = 33'(t3_ff); mul_b = 33'(t_ff); end
         ngd_pkg::BK_D6:   begin mul_a = 33'(t3_ff >> 1); mul_b = ngd_pkg::RECIP_3; end
         ngd_pkg::BK_D24:  begin mul_a = 33'(t4_ff >> 3); mul_b = ngd_pkg::RECIP_3; end
         ngd_pkg::BK_SQ:   begin mul_a = p_ff; mul_b = p_ff; end
         ngd_pkg::BK_G1:   begin mul_a = 33'(f_ff[31:0]); mul_b = p_ff; end
         ngd_pkg::BK_G2:   begin mul_a = 33'(f_ff[63:32]); mul_b = p_ff; end
         ngd_pkg::BK_W1:   begin mul_a = 33'(g_ff[31:0]); mul_b = 33'(mass_ff); end
         ngd_pkg::BK_W2:   begin mul_a = 33'(g_ff[63:32]); mul_b = 33'(mass_ff); end
         default:          begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod     = 66'(mul_a) * 66'(mul_b);
   assign sq_trial = sq_res_ff + sq_bit_ff;
   assign rem_sh   = {rem_ff, dvd_ff[63]};
   assign div_ge   = rem_sh >= {1'b0, div_ff};
   assign poly     = {2'b01, 32'b0} - 34'(t_ff) + 34'(t2_ff >> 1) - 34'(c6_ff) + 34'(c24_ff);
   assign sq_round = prod + 66'(64'h8000_0000);
   assign acc_sum  = 33'(acc_ff) + 33'(term_ff[31:0]);
   assign idx_next = idx_ff + 1'b1;

   assign rd_addr = {job_ff.bank, idx_ff[ngd_pkg::IDX_W-1:0]};

   always_comb begin
      state_in = state_ff;   job_in = job_ff;     idx_in = idx_ff;   step_in = step_ff;
      sq_v_in = sq_v_ff;     sq_res_in = sq_res_ff; sq_bit_in = sq_bit_ff;
      f_in = f_ff;           dvd_in = dvd_ff;     quo_in = quo_ff;   div_in = div_ff;
      rem_in = rem_ff;       s2_in = s2_ff;       mass_in = mass_ff; x_in = x_ff;
      t_in = t_ff;           t2_in = t2_ff;       t3_in = t3_ff;     t4_in = t4_ff;
      c6_in = c6_ff;         c24_in = c24_ff;     acc_in = acc_ff;   p_in = p_ff;
      lo_in = lo_ff;         g_in = g_ff;         term_in = term_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_dens_in  = out_dens_ff;
      out_stat_in  = out_stat_ff;
      job_pop  = 1'b0;
      job_done = 1'b0;
      rd_en    = 1'b0;
      unique case (state_ff)
         ngd_pkg::BK_IDLE: begin
            if (job_valid) begin
               job_pop   = 1'b1;
               job_in    = job;
               acc_in    = '0;
               idx_in    = '0;
               step_in   = '0;
               sq_v_in   = {job.max, 32'b0};
               sq_res_in = '0;
               sq_bit_in = 64'h1 << 62;
               state_in  = (job.status != ngd_pkg::ST_OK) ? ngd_pkg::BK_OUT
                                                          : ngd_pkg::BK_SQRT;
            end
         end
         ngd_pkg::BK_SQRT: begin
            if (sq_v_ff >= sq_trial) begin
               sq_v_in   = sq_v_ff - sq_trial;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            step_in   = step_ff + 1'b1;
            if (step_ff == 6'd31) begin
               state_in = ngd_pkg::BK_MULF;
            end
         end
         ngd_pkg::BK_MULF: begin
            dvd_in   = {1'b0, prod[46:0], 16'b0};
            div_in   = sq_res_ff[31:0];
            rem_in   = '0;
            quo_in   = '0;
            step_in  = '0;
            state_in = ngd_pkg::BK_DIVF;
         end
         ngd_pkg::BK_DIVF, ngd_pkg::BK_DIVQ: begin
            rem_in  = div_ge ? 32'(rem_sh - {1'b0, div_ff}) : rem_sh[31:0];
            quo_in  = {quo_ff[62:0], div_ge};
            dvd_in  = dvd_ff << 1;
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd63) begin
               if (state_ff == ngd_pkg::BK_DIVF) begin
                  f_in     = {quo_ff[62:0], div_ge};
                  state_in = ngd_pkg::BK_MULS;
               end else begin
                  state_in = ngd_pkg::BK_MULX;
               end
            end
         end
         ngd_pkg::BK_MULS: begin
            s2_in    = prod[31:0];
            state_in = ngd_pkg::BK_RD;
         end
         ngd_pkg::BK_RD: begin
            rd_en    = 1'b1;
            state_in = ngd_pkg::BK_RDW;
         end
         ngd_pkg::BK_RDW: begin
            dvd_in   = {1'b0, rd_data[31:0], 31'b0};
            mass_in  = rd_data[63:32];
            div_in   = job_ff.max;
            rem_in   = '0;
            quo_in   = '0;
            step_in  = '0;
            state_in = ngd_pkg::BK_DIVQ;
         end
         ngd_pkg::BK_MULX: begin
            x_in     = prod[63:32];
            state_in = ngd_pkg::BK_EXPC;
         end
         ngd_pkg::BK_EXPC: begin
            if (x_ff == '0) begin
               p_in     = {1'b1, 32'b0};
               state_in = ngd_pkg::BK_G1;
            end else if (x_ff >= ngd_pkg::EXP_LIMIT) begin
               p_in     = '0;
               state_in = ngd_pkg::BK_G1;
            end else begin
               t_in     = {x_ff[23:0], 8'b0};
               state_in = ngd_pkg::BK_T2;
            end
         end
         ngd_pkg::BK_T2:  begin t2_in = prod[63:32]; state_in = ngd_pkg::BK_T3; end
         ngd_pkg::BK_T3:  begin t3_in = prod[63:32]; state_in = ngd_pkg::BK_T4; end
         ngd_pkg::BK_T4:  begin t4_in = prod[63:32]; state_in = ngd_pkg::BK_D6; end
         ngd_pkg::BK_D6:  begin c6_in = 32'(prod[65:33]); state_in = ngd_pkg::BK_D24; end
         ngd_pkg::BK_D24: begin c24_in = 32'(prod[65:33]); state_in = ngd_pkg::BK_POLY; end
         ngd_pkg::BK_POLY: begin
            p_in     = poly[32:0];
            step_in  = '0;
            state_in = ngd_pkg::BK_SQ;
         end
         ngd_pkg::BK_SQ: begin
            p_in    = sq_round[64:32];
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd7) begin
               state_in = ngd_pkg::BK_G1;
            end
         end
         ngd_pkg::BK_G1: begin
            lo_in    = prod[64:0];
            state_in = ngd_pkg::BK_G2;
         end
         ngd_pkg::BK_G2: begin
            g_in = prod[63:0] + 64'(lo_ff >> 32);
            if (weighted_mode) begin
               state_in = ngd_pkg::BK_W1;
            end else begin
               term_in  = (prod[63:0] + 64'(lo_ff >> 32)) >> 16;
               state_in = ngd_pkg::BK_ACC;
            end
         end
         ngd_pkg::BK_W1: begin
            lo_in    = prod[64:0];
            state_in = ngd_pkg::BK_W2;
         end
         ngd_pkg::BK_W2: begin
            term_in  = prod[63:0] + 64'(lo_ff >> 32);
            state_in = ngd_pkg::BK_ACC;
         end
         ngd_pkg::BK_ACC: begin
            if (term_ff[63:32] != '0 || term_ff[31:0] == '1 || acc_sum[32]) begin
               acc_in = '1;
            end else begin
               acc_in = acc_sum[31:0];
            end
            idx_in   = idx_next;
            state_in = (idx_next == job_ff.count) ? ngd_pkg::BK_OUT : ngd_pkg::BK_RD;
         end
         ngd_pkg::BK_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_dens_in  = acc_ff;
               out_stat_in  = job_ff.status;
               job_done     = 1'b1;
               state_in     = ngd_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = ngd_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;   idx_ff <= idx_in;       step_ff <= step_in;
      sq_v_ff <= sq_v_in; sq_res_ff <= sq_res_in; sq_bit_ff <= sq_bit_in;
      f_ff <= f_in;       dvd_ff <= dvd_in;       quo_ff <= quo_in;
      div_ff <= div_in;   rem_ff <= rem_in;       s2_ff <= s2_in;
      mass_ff <= mass_in; x_ff <= x_in;           t_ff <= t_in;
      t2_ff <= t2_in;     t3_ff <= t3_in;         t4_ff <= t4_in;
      c6_ff <= c6_in;     c24_ff <= c24_in;       acc_ff <= acc_in;
      p_ff <= p_in;       lo_ff <= lo_in;         g_ff <= g_in;
      term_ff <= term_in; out_dens_ff <= out_dens_in; out_stat_ff <= out_stat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ngd_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_dens_ff;
   assign rsp_tuser  = out_stat_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ngd_pkg::ST_OK |-> rsp_tdata == '0)
      else $error("error result carries nonzero density");

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      job_done |=> state_ff == ngd_pkg::BK_IDLE && rsp_tvalid)
      else $error("job completion without result");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> idx_ff < job_ff.count && job_ff.status == ngd_pkg::ST_OK)
      else $error("store read beyond set");

endmodule
